### rtl/hsbo_pkg.sv
package hsbo_pkg;

    localparam int START_X_W   = 10;
    localparam int ROW_Y_W     = 9;
    localparam int SPAN_LEN_W  = 10;
    localparam int ADDR_W      = 16;
    localparam int MASK_W      = 8;
    localparam int RUN_W       = 7;
    localparam int CMD_SLOTS   = 3;
    localparam int CMD_CNT_W   = 2;

    localparam int DEF_BYTES_PER_ROW = 80;

    typedef enum logic [1:0] {
        OP_OR   = 2'd0,
        OP_AND  = 2'd1,
        OP_FILL = 2'd2
    } hsbo_op_t;

    typedef struct packed {
        logic [START_X_W-1:0]  start_x;
        logic [ROW_Y_W-1:0]    row_y;
        logic [SPAN_LEN_W-1:0] span_len;
        logic                  pixel_on;
    } hsbo_item_t;

    typedef struct packed {
        hsbo_op_t          op_kind;
        logic [ADDR_W-1:0] byte_addr;
        logic [MASK_W-1:0] mask_value;
        logic [RUN_W-1:0]  run_count;
        logic              last_op;
    } hsbo_result_t;

    // all byte commands of one line, in output order, with their count
    typedef struct packed {
        hsbo_result_t [CMD_SLOTS-1:0] cmd;
        logic [CMD_CNT_W-1:0]         n;
    } hsbo_cmd_set_t;

endpackage

### rtl/hsbo_span_calc.sv
module hsbo_span_calc
    import hsbo_pkg::*;
#(
    parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW
)
(
    input  hsbo_item_t        item,
    input  logic [ADDR_W-1:0] bitmap_base,
    output hsbo_cmd_set_t     cmd_set
);

    localparam int BprW  = $clog2(BYTES_PER_ROW + 1);
    localparam int ProdW = ROW_Y_W + BprW;
    localparam int EndW  = START_X_W + 1;

    logic [ProdW-1:0]  row_prod;
    logic [ADDR_W-1:0] row_addr;
    logic [2:0]        first;
    logic [EndW-1:0]   span_end;
    logic [EndW-1:0]   first_plus_len;
    logic [EndW-1:0]   whole_diff;
    logic [2:0]        tail;
    logic              single;
    logic [MASK_W-1:0] head_shr;
    logic [MASK_W-1:0] end_shr;
    logic [MASK_W-1:0] single_mask;
    logic [MASK_W-1:0] lead_mask;
    logic [MASK_W-1:0] tail_mask;
    logic [RUN_W-1:0]  whole;
    logic [EndW-4:0]   fill_idx;
    hsbo_result_t      lead_cmd;
    hsbo_result_t      fill_cmd;
    hsbo_result_t      tail_cmd;
    hsbo_result_t      one_cmd;

    function automatic hsbo_result_t mask_cmd(input logic on, input logic [ADDR_W-1:0] addr,
                                              input logic [MASK_W-1:0] mask);
        hsbo_result_t c;
        c.op_kind    = on ? OP_OR : OP_AND;
        c.byte_addr  = addr;
        c.mask_value = on ? mask : ~mask;
        c.run_count  = RUN_W'(1);
        c.last_op    = 1'b0;
        return c;
    endfunction

    always_comb
    begin
        row_prod       = ProdW'(item.row_y) * ProdW'(BYTES_PER_ROW);
        row_addr       = bitmap_base + ADDR_W'(row_prod);
        first          = item.start_x[2:0];
        span_end       = EndW'(item.start_x) + EndW'(item.span_len);
        tail           = span_end[2:0];
        first_plus_len = EndW'(first) + EndW'(item.span_len);
        single         = (first_plus_len <= EndW'(8));

        head_shr    = 8'hFF >> first;
        end_shr     = (first_plus_len >= EndW'(8)) ? '0 : (8'hFF >> first_plus_len[2:0]);
        single_mask = head_shr & ~end_shr;
        lead_mask   = head_shr;
        tail_mask   = ~(8'hFF >> tail);

        // whole bytes between the rounded-down end and the start column
        whole_diff = {span_end[EndW-1:3], 3'b000} - EndW'(item.start_x);
        whole      = whole_diff[RUN_W+2:3];
        fill_idx   = (EndW-3)'(item.start_x[START_X_W-1:3]) + (EndW-3)'(first != 3'd0);

        one_cmd  = mask_cmd(item.pixel_on,
                            row_addr + ADDR_W'(item.start_x[START_X_W-1:3]), single_mask);
        lead_cmd = mask_cmd(item.pixel_on,
                            row_addr + ADDR_W'(item.start_x[START_X_W-1:3]), lead_mask);
        tail_cmd = mask_cmd(item.pixel_on,
                            row_addr + ADDR_W'(span_end[EndW-1:3]), tail_mask);

        fill_cmd.op_kind    = OP_FILL;
        fill_cmd.byte_addr  = row_addr + ADDR_W'(fill_idx);
        fill_cmd.mask_value = item.pixel_on ? 8'hFF : 8'h00;
        fill_cmd.run_count  = whole;
        fill_cmd.last_op    = 1'b0;

        cmd_set = '0;
        if (item.span_len != '0)
        begin
            if (single)
            begin
                cmd_set.cmd[0] = one_cmd;
                cmd_set.n      = CMD_CNT_W'(1);
            end
            else
            begin
                if (first != 3'd0)
                begin
                    cmd_set.cmd[cmd_set.n] = lead_cmd;
                    cmd_set.n              = cmd_set.n + CMD_CNT_W'(1);
                end
                if (whole != '0)
                begin
                    cmd_set.cmd[cmd_set.n] = fill_cmd;
                    cmd_set.n              = cmd_set.n + CMD_CNT_W'(1);
                end
                if (tail != 3'd0)
                begin
                    cmd_set.cmd[cmd_set.n] = tail_cmd;
                    cmd_set.n              = cmd_set.n + CMD_CNT_W'(1);
                end
            end
            if (cmd_set.n != '0)
            begin
                cmd_set.cmd[cmd_set.n - CMD_CNT_W'(1)].last_op = 1'b1;
            end
        end
    end

endmodule

### rtl/hsbo_cmd_queue.sv
module hsbo_cmd_queue
    import hsbo_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  hsbo_cmd_set_t cmd_set,
    output logic          free,
    output logic          result_valid,
    output hsbo_result_t  result
);

    hsbo_result_t [CMD_SLOTS-1:0] cmd_reg;
    hsbo_result_t [CMD_SLOTS-1:0] cmd_next;
    logic [CMD_CNT_W-1:0]         cnt_reg;
    logic [CMD_CNT_W-1:0]         cnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    hsbo_result_t                 out_reg;
    hsbo_result_t                 out_next;

    // a load may land in the same cycle that the last queued command leaves
    assign free = (cnt_reg <= CMD_CNT_W'(1));

    always_comb
    begin
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = (cnt_reg != '0);
        out_next       = (cnt_reg != '0) ? cmd_reg[0] : out_reg;
        if (load)
        begin
            cmd_next = cmd_set.cmd;
            cnt_next = cmd_set.n;
        end
        else if (cnt_reg != '0)
        begin
            for (int i = 0; i < CMD_SLOTS - 1; i++)
            begin
                cmd_next[i] = cmd_reg[i + 1];
            end
            cnt_next = cnt_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/horizontal_span_byte_ops.sv
// Turns a horizontal line request on a 1 bpp, MSB-first bitmap into up to three
// byte commands (leading masked byte, one whole-byte fill run, trailing masked
// byte), or one masked byte for a span within a byte. A request is taken when
// start is high and busy is low; it waits in the input register, busy high, while
// the command queue has no room, and its first command then leaves via the queue
// and the output register on result, marked by result_valid; the rest follow on
// consecutive cycles. Commands cannot be held off. The single result port issues
// one command per cycle; a request makes 1 to 3 commands, none for a zero length.
// Requests are taken every cycle while each makes at most one command.
// Write bitmap_base through cfg_we/cfg_wdata only while no request is in flight.
module horizontal_span_byte_ops
    import hsbo_pkg::*;
#(
    parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hsbo_item_t        item,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    output logic              result_valid,
    output hsbo_result_t      result
);

    logic              in_valid_reg;
    logic              in_valid_next;
    hsbo_item_t        in_item_reg;
    hsbo_item_t        in_item_next;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic              accept;
    logic              load;
    logic              q_free;
    hsbo_cmd_set_t     cmd_set;

    assign busy   = in_valid_reg && !q_free;
    assign accept = start && !busy;
    assign load   = in_valid_reg && q_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        base_next     = cfg_we ? cfg_wdata : base_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = item;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            base_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    hsbo_span_calc #(
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_calc (
        .item        (in_item_reg),
        .bitmap_base (base_reg),
        .cmd_set     (cmd_set)
    );

    hsbo_cmd_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .cmd_set      (cmd_set),
        .free         (q_free),
        .result_valid (result_valid),
        .result       (result)
    );

    a_busy_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_valid_reg)
        else $error("busy without a pending item");

    a_load_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cmd_set.n != '0) |-> ##2 result_valid)
        else $error("loaded commands did not reach the output");

    a_line_is_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_op) |=> result_valid)
        else $error("gap inside the commands of one line");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.run_count != '0))
        else $error("command with zero run count");

endmodule
